// ----- rtl/sobel_edge_threshold_core_assert.svh -----
// Assertion macros shared by the Sobel edge threshold RTL.
// Needs nothing else; included by the modules that check their own logic.
`ifndef SOBEL_EDGE_THRESHOLD_CORE_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SOBTH_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobel_edge_threshold: implication check failed");

// Next-cycle implication, disabled during reset.
`define SOBTH_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobel_edge_threshold: next-cycle check failed");

`endif

// ----- rtl/sobth_pkg.sv -----
// Shared types and constants of the Sobel edge threshold core.
// No dependencies; imported by every module of the block but sobth_ram.
`default_nettype none

package sobth_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_THR_W  = 9;
  localparam int THR_SQ_W   = 2 * CFG_THR_W;

  localparam int RST_IMAGE_WIDTH    = 640;
  localparam int RST_IMAGE_HEIGHT   = 480;
  localparam int RST_EDGE_THRESHOLD = 128;
  localparam int RST_THR_SQ         = RST_EDGE_THRESHOLD * RST_EDGE_THRESHOLD;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_index_t;

  // Frame geometry
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_SIZE       = 3;
  localparam int OUT_POS_W      = 10;
  localparam int PIXEL_W        = 24;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divide by three: floor(x * 683 / 2048) is exact for x <= 765
  localparam int AVG_SUM_W   = 10;
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;
  localparam int DIV_PROD_W  = 20;
  localparam int GRAD_W      = 8;
  localparam int SQ_W        = 2 * GRAD_W;
  localparam int MAG_W       = SQ_W + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 edge_res;
    logic                 frame_done;
  } out_item_t;

  // Which results one pixel triggers, in emission order: inner, row end, bottom.
  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 has_inner;
    logic                 inner_full;
    logic                 has_row_end;
    logic                 has_bottom;
    logic                 frame_end;
  } job_meta_t;

  typedef struct packed {
    in_item_t [2:0][2:0] win;
    job_meta_t           meta;
  } job_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/sobth_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sobth_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sobth_front.sv -----
// Front end: pixel intake, raster counters, line stores, 3x3 window, job build.
// Depends on sobth_pkg, sobth_ram and the assertion macro header.
`default_nettype none
`include "sobel_edge_threshold_core_assert.svh"

module sobth_front #(
  parameter int MAX_WIDTH  = sobth_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobth_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  sobth_pkg::in_item_t                  pix,
  input  logic [sobth_pkg::CFG_SIZE_W-1:0]     image_width,
  input  logic [sobth_pkg::CFG_SIZE_W-1:0]     image_height,
  input  sobth_pkg::q_status_t                 q_status,
  output logic                                 push,
  output sobth_pkg::job_t                      job
);
  import sobth_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (COL_W + 1 > CFG_SIZE_W) ? COL_W + 1 : CFG_SIZE_W;
  localparam int HCMP_W = (ROW_W + 1 > CFG_SIZE_W) ? ROW_W + 1 : CFG_SIZE_W;

  logic             accept;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] w_last, col_sat;
  logic [ROW_W-1:0] h_last, row_sat;
  logic [WCMP_W-1:0] width_ext;
  logic [HCMP_W-1:0] height_ext;
  logic             last_col, last_row;
  job_meta_t        meta_next;

  logic             f1_valid;
  in_item_t         f1_pix;
  logic [COL_W-1:0] f1_col;
  job_meta_t        f1_meta;

  logic [PIXEL_W-1:0]  older_rd, newer_rd;
  in_item_t [2:0][2:0] window, window_next;

  // Credit check: room for this pixel's job and the one still in flight.
  assign pix_stall = ({1'b0, q_status.count} + {{QCNT_W{1'b0}}, f1_valid})
                     >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept = pix_valid && !pix_stall;

  always_comb begin
    width_ext  = WCMP_W'(image_width);
    height_ext = HCMP_W'(image_height);
    if (width_ext < WCMP_W'(MIN_SIZE)) begin
      w_last = COL_W'(MIN_SIZE - 1);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_ext - WCMP_W'(1));
    end
    if (height_ext < HCMP_W'(MIN_SIZE)) begin
      h_last = ROW_W'(MIN_SIZE - 1);
    end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(height_ext - HCMP_W'(1));
    end
  end

  // Clip the position to the current frame size, then classify.
  always_comb begin
    col_sat  = (col_count > w_last) ? w_last : col_count;
    row_sat  = (row_count > h_last) ? h_last : row_count;
    last_col = (col_sat == w_last);
    last_row = (row_sat == h_last);
    meta_next.row         = OUT_POS_W'(row_sat);
    meta_next.col         = OUT_POS_W'(col_sat);
    meta_next.has_inner   = (row_sat != '0) && (col_sat != '0);
    meta_next.inner_full  = (row_sat > ROW_W'(1)) && (col_sat > COL_W'(1));
    meta_next.has_row_end = (row_sat != '0) && last_col;
    meta_next.has_bottom  = last_row;
    meta_next.frame_end   = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      f1_valid  <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_sat + ROW_W'(1);
        end else begin
          col_count <= col_sat + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix  <= pix;
      f1_col  <= col_sat;
      f1_meta <= meta_next;
    end
  end

  // Line stores: read at intake, rotated in the next cycle.
  sobth_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (f1_valid),
    .waddr (f1_col),
    .wdata (newer_rd),
    .re    (accept),
    .raddr (col_sat),
    .rdata (older_rd)
  );

  sobth_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk   (clk),
    .we    (f1_valid),
    .waddr (f1_col),
    .wdata (f1_pix),
    .re    (accept),
    .raddr (col_sat),
    .rdata (newer_rd)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r][0] = window[r][1];
      window_next[r][1] = window[r][2];
    end
    window_next[0][2] = older_rd;
    window_next[1][2] = newer_rd;
    window_next[2][2] = f1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (f1_valid) begin
      window <= window_next;
    end
  end

  // Drop jobs that yield no result (the top row, and column 0 above the last row).
  assign push = f1_valid &&
                (f1_meta.has_inner || f1_meta.has_row_end || f1_meta.has_bottom);
  assign job.win  = window_next;
  assign job.meta = f1_meta;

  `SOBTH_ASSERT_IMP(a_frame_end_has_row_end, clk, rst, push,
                    (!job.meta.frame_end || job.meta.has_row_end))
  `SOBTH_ASSERT_NXT(a_frame_wraps, clk, rst, accept && last_col && last_row,
                    (row_count == '0) && (col_count == '0))

endmodule

`default_nettype wire

// ----- rtl/sobth_queue.sv -----
// Short job queue between front and back; register-based storage.
// Depends on sobth_pkg and the assertion macro header.
`default_nettype none
`include "sobel_edge_threshold_core_assert.svh"

module sobth_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sobth_pkg::job_t      job,
  input  logic                 pop,
  output sobth_pkg::job_t      head,
  output sobth_pkg::q_status_t status
);
  import sobth_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              full;

  assign full          = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty  = (count == '0);
  assign status.count  = count;
  assign head          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job;
    end
  end

  `SOBTH_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
  `SOBTH_ASSERT_IMP(a_no_underflow, clk, rst, pop, !status.empty)

endmodule

`default_nettype wire

// ----- rtl/sobth_back.sv -----
// Back end: expands each job into results and runs the gradient pipeline.
// Depends on sobth_pkg and the assertion macro header.
`default_nettype none
`include "sobel_edge_threshold_core_assert.svh"

module sobth_back (
  input  logic                               clk,
  input  logic                               rst,
  input  sobth_pkg::job_t                    head,
  input  sobth_pkg::q_status_t               q_status,
  output logic                               pop,
  input  logic [sobth_pkg::THR_SQ_W-1:0]     thr_sq,
  output logic                               res_valid,
  input  logic                               res_stall,
  output sobth_pkg::out_item_t               res
);
  import sobth_pkg::*;

  localparam int KSUM_W = 11;
  typedef logic [KSUM_W-1:0] ksum_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 frame_done;
  } pos_t;

  function automatic logic [7:0] chan(in_item_t p, logic [1:0] k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = p.red;
      2'd1:    c = p.green;
      default: c = p.blue;
    endcase
    return c;
  endfunction

  function automatic ksum_t ext1(logic [7:0] c);
    return {3'b000, c};
  endfunction

  function automatic ksum_t ext2(logic [7:0] c);
    return {2'b00, c, 1'b0};
  endfunction

  function automatic logic [7:0] clamp8(ksum_t s);
    logic [7:0] c;
    if (s[KSUM_W-1]) begin
      c = 8'd0;
    end else if (s[KSUM_W-2:8] != '0) begin
      c = 8'd255;
    end else begin
      c = s[7:0];
    end
    return c;
  endfunction

  logic [2:0] flags, remaining, pick, done_mask;
  logic       adv, issue, full_sel;
  in_item_t   own;
  pos_t       pos_sel;
  ksum_t      hs_next [3];
  ksum_t      vs_next [3];

  logic       b1_valid, b2_valid, b3_valid;
  ksum_t      b1_hs [3];
  ksum_t      b1_vs [3];
  pos_t       b1_pos, b2_pos, b3_pos;
  logic [GRAD_W-1:0]     b2_h, b2_v;
  logic [SQ_W-1:0]       b3_hsq, b3_vsq;
  logic [AVG_SUM_W-1:0]  h_total, v_total;
  logic [DIV_PROD_W-1:0] h_prod, v_prod;
  logic [MAG_W-1:0]      mag;

  // Walk the results of the head job, lowest flag first.
  assign flags     = {head.meta.has_bottom, head.meta.has_row_end, head.meta.has_inner};
  assign remaining = flags & ~done_mask;
  assign pick      = remaining & (~remaining + 3'd1);
  assign adv       = !res_valid || !res_stall;
  assign issue     = adv && !q_status.empty;
  assign pop       = issue && ((remaining & ~pick) == 3'b000);

  always_comb begin
    own      = head.win[2][2];
    full_sel = 1'b0;
    pos_sel.row        = head.meta.row;
    pos_sel.col        = head.meta.col;
    pos_sel.frame_done = head.meta.frame_end;
    priority if (pick[0]) begin
      own                = head.win[1][1];
      full_sel           = head.meta.inner_full;
      pos_sel.row        = head.meta.row - OUT_POS_W'(1);
      pos_sel.col        = head.meta.col - OUT_POS_W'(1);
      pos_sel.frame_done = 1'b0;
    end else if (pick[1]) begin
      own                = head.win[1][2];
      pos_sel.row        = head.meta.row - OUT_POS_W'(1);
      pos_sel.frame_done = 1'b0;
    end else begin
      own = head.win[2][2];
    end
  end

  // Kernel sums per channel; a border pixel passes its own channels through.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (full_sel) begin
        hs_next[k] = ext1(chan(head.win[2][0], 2'(k))) + ext2(chan(head.win[2][1], 2'(k)))
                   + ext1(chan(head.win[2][2], 2'(k))) - ext1(chan(head.win[0][0], 2'(k)))
                   - ext2(chan(head.win[0][1], 2'(k))) - ext1(chan(head.win[0][2], 2'(k)));
        vs_next[k] = ext1(chan(head.win[0][0], 2'(k))) + ext2(chan(head.win[1][0], 2'(k)))
                   + ext1(chan(head.win[2][0], 2'(k))) - ext1(chan(head.win[0][2], 2'(k)))
                   - ext2(chan(head.win[1][2], 2'(k))) - ext1(chan(head.win[2][2], 2'(k)));
      end else begin
        hs_next[k] = ext1(chan(own, 2'(k)));
        vs_next[k] = ext1(chan(own, 2'(k)));
      end
    end
  end

  // Clamp, sum and divide by three.
  always_comb begin
    h_total = AVG_SUM_W'(clamp8(b1_hs[0])) + AVG_SUM_W'(clamp8(b1_hs[1]))
            + AVG_SUM_W'(clamp8(b1_hs[2]));
    v_total = AVG_SUM_W'(clamp8(b1_vs[0])) + AVG_SUM_W'(clamp8(b1_vs[1]))
            + AVG_SUM_W'(clamp8(b1_vs[2]));
    h_prod  = DIV_PROD_W'(h_total) * DIV_PROD_W'(DIV3_MUL);
    v_prod  = DIV_PROD_W'(v_total) * DIV_PROD_W'(DIV3_MUL);
  end

  assign mag = MAG_W'(b3_hsq) + MAG_W'(b3_vsq);

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (issue) begin
        done_mask <= pop ? 3'b000 : (done_mask | pick);
      end
      if (adv) begin
        b1_valid  <= issue;
        b2_valid  <= b1_valid;
        b3_valid  <= b2_valid;
        res_valid <= b3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_hs  <= hs_next;
      b1_vs  <= vs_next;
      b1_pos <= pos_sel;
      b2_h   <= h_prod[DIV3_SHIFT +: GRAD_W];
      b2_v   <= v_prod[DIV3_SHIFT +: GRAD_W];
      b2_pos <= b1_pos;
      b3_hsq <= {8'd0, b2_h} * {8'd0, b2_v & 8'd0 | b2_h};
      b3_vsq <= {8'd0, b2_v} * {8'd0, b2_v};
      b3_pos <= b2_pos;
      res.out_row    <= b3_pos.row;
      res.out_col    <= b3_pos.col;
      res.frame_done <= b3_pos.frame_done;
      res.edge_res   <= (THR_SQ_W'(mag) > thr_sq);
    end
  end

  `SOBTH_ASSERT_IMP(a_job_not_overrun, clk, rst, !q_status.empty,
                    ((done_mask & flags) != flags))

endmodule

`default_nettype wire

// ----- rtl/sobel_edge_threshold_core.sv -----
// Sobel edge threshold core, top level: APB register file, front, queue, back.
// Depends on sobth_pkg, sobth_front, sobth_queue, sobth_back, sobth_ram.
// Throughput: one result per cycle from the back while the output is not stalled;
// one pixel per cycle while the queue has credit and each pixel yields at most
// one result; a row-end pixel below row 0 or last-row pixel past column 0 yields
// two results, the final three. Reset: counters, queue and window cleared,
// registers back to 640 x 480 / 128; line stores are not cleared.
`default_nettype none

module sobel_edge_threshold_core #(
  parameter int MAX_WIDTH  = sobth_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobth_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  // pixel input channel
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  sobth_pkg::in_item_t                pix,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output sobth_pkg::out_item_t               res,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sobth_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sobth_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sobth_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import sobth_pkg::*;

  logic [CFG_SIZE_W-1:0] image_width;
  logic [CFG_SIZE_W-1:0] image_height;
  logic [CFG_THR_W-1:0]  edge_threshold;
  logic [THR_SQ_W-1:0]   thr_sq;
  logic                  cfg_write;
  reg_index_t            cfg_index;

  q_status_t q_status;
  logic      push, pop;
  job_t      job, head;

  // Register file. The port is always ready: every access cycle completes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);

  // Keep the squared threshold next to the raw value so the compare stage
  // needs no multiplier of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_SIZE_W'(RST_IMAGE_WIDTH);
      image_height   <= CFG_SIZE_W'(RST_IMAGE_HEIGHT);
      edge_threshold <= CFG_THR_W'(RST_EDGE_THRESHOLD);
      thr_sq         <= THR_SQ_W'(RST_THR_SQ);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width <= pwdata[CFG_SIZE_W-1:0];
        REG_IMAGE_HEIGHT:   image_height <= pwdata[CFG_SIZE_W-1:0];
        REG_EDGE_THRESHOLD: begin
          edge_threshold <= pwdata[CFG_THR_W-1:0];
          thr_sq         <= {{CFG_THR_W{1'b0}}, pwdata[CFG_THR_W-1:0]}
                          * {{CFG_THR_W{1'b0}}, pwdata[CFG_THR_W-1:0]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_IMAGE_WIDTH:    prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT:   prdata = CFG_DATA_W'(image_height);
      REG_EDGE_THRESHOLD: prdata = CFG_DATA_W'(edge_threshold);
      default:            prdata = '0;
    endcase
  end

  // Front: take one pixel per cycle while the queue has credit, rotate the
  // line stores, advance the window and hand a classified job to the queue.
  sobth_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pix          (pix),
    .image_width  (image_width),
    .image_height (image_height),
    .q_status     (q_status),
    .push         (push),
    .job          (job)
  );

  // Queue: absorb the extra results of row ends and the bottom row so the
  // front keeps streaming while the back catches up.
  sobth_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job    (job),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // Back: issue one result transaction per cycle through the gradient
  // pipeline; the whole pipeline holds while the output register is stalled.
  sobth_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .thr_sq    (thr_sq),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// ----- dv/tb_sobel_edge_threshold_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_threshold_core: streams RGB frames and checks every result.
// Depends on sobth_pkg and the core RTL; predicts row, column, edge and frame end itself.

module tb_sobel_edge_threshold_core;
  import sobth_pkg::*;

  localparam int RANDOM_ITEMS  = 130;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 10;
  localparam int CYCLE_LIMIT   = 600_000;

  typedef enum int {PIX_NOISE, PIX_RAMP, PIX_SATURATED, PIX_DIM} pixel_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  in_item_t              pix = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  out_item_t             res;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sobel_edge_threshold_core DUT (
    .clk, .rst,
    .pix_valid, .pix_stall, .pix,
    .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Pixels waiting to be offered, and results the frame model says must come out.
  in_item_t  pixel_queue[$];
  out_item_t expected_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int pixels_pushed  = 0;
  int ramp_index     = 0;

  // Idling controls: the stimulus sets the idle flags and hold requests, the driver and receiver count down the rest.
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int send_gap       = 0;
  int stall_left     = 0;
  int hold_left      = 0;

  // Frame model: register copies, line stores, 3x3 window and the position of the next pixel.
  logic [CFG_SIZE_W-1:0] cfg_width  = CFG_SIZE_W'(RST_IMAGE_WIDTH);
  logic [CFG_SIZE_W-1:0] cfg_height = CFG_SIZE_W'(RST_IMAGE_HEIGHT);
  logic [CFG_THR_W-1:0]  cfg_thr    = CFG_THR_W'(RST_EDGE_THRESHOLD);
  in_item_t older_line [DEF_MAX_WIDTH] = '{default: '0};
  in_item_t newer_line [DEF_MAX_WIDTH] = '{default: '0};
  in_item_t win [3][3] = '{default: '0};
  int next_row = 0;
  int next_col = 0;

  function automatic int clamp_size(int v, int hi);
    return (v < MIN_SIZE) ? MIN_SIZE : ((v > hi) ? hi : v);
  endfunction

  function automatic int chan_of(in_item_t p, int k);
    case (k)
      0:       return int'(p.red);
      1:       return int'(p.green);
      default: return int'(p.blue);
    endcase
  endfunction

  function automatic int channel_avg(in_item_t p);
    return (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
  endfunction

  // Apply one Sobel kernel per channel, clamp each channel to 0..255, then average.
  // Horizontal: row below minus row above. Vertical: left column minus right column.
  function automatic int gradient(bit vertical);
    int total;
    int sum;
    int wgt;
    total = 0;
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int rr = 0; rr < 3; rr++) begin
        for (int cc = 0; cc < 3; cc++) begin
          wgt = vertical ? (1 - cc) * ((rr == 1) ? 2 : 1) : (rr - 1) * ((cc == 1) ? 2 : 1);
          sum += chan_of(win[rr][cc], k) * wgt;
        end
      end
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      total += sum;
    end
    return total / 3;
  endfunction

  function automatic bit is_edge(int gh, int gv);
    return (gh * gh + gv * gv) > (int'(cfg_thr) * int'(cfg_thr));
  endfunction

  function automatic out_item_t make_result(int r, int c, bit e, bit d);
    return '{out_row: OUT_POS_W'(r), out_col: OUT_POS_W'(c), edge_res: e, frame_done: d};
  endfunction

  // Advance the frame model by one accepted pixel and queue the results it releases:
  // the pixel up and left, the row-end pixel above, and in the last row the pixel itself.
  task automatic predict_pixel(in_item_t p);
    int  w;
    int  h;
    int  row;
    int  col;
    int  avg;
    bit  last_col;
    bit  last_row;
    w = clamp_size(int'(cfg_width), DEF_MAX_WIDTH);
    h = clamp_size(int'(cfg_height), DEF_MAX_HEIGHT);
    // A size shrunk mid-frame pins the position to the last row or column.
    if (next_col > w - 1) next_col = w - 1;
    if (next_row > h - 1) next_row = h - 1;
    row = next_row;
    col = next_col;
    for (int rr = 0; rr < 3; rr++) begin
      win[rr][0] = win[rr][1];
      win[rr][1] = win[rr][2];
    end
    win[0][2] = older_line[col];
    win[1][2] = newer_line[col];
    win[2][2] = p;
    older_line[col] = newer_line[col];
    newer_line[col] = p;
    last_col = (col == w - 1);
    last_row = (row == h - 1);
    if (row >= 1 && col >= 1) begin
      if (row >= 2 && col >= 2) begin
        expected_results.push_back(make_result(row - 1, col - 1,
                                               is_edge(gradient(1'b0), gradient(1'b1)), 1'b0));
      end else begin
        // Border pixels judge their own average against itself.
        avg = channel_avg(win[1][1]);
        expected_results.push_back(make_result(row - 1, col - 1, is_edge(avg, avg), 1'b0));
      end
    end
    if (row >= 1 && last_col) begin
      avg = channel_avg(win[1][2]);
      expected_results.push_back(make_result(row - 1, col, is_edge(avg, avg), 1'b0));
    end
    if (last_row) begin
      avg = channel_avg(p);
      expected_results.push_back(make_result(row, col, is_edge(avg, avg), last_col));
    end
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : row + 1;
    end else begin
      next_col = col + 1;
    end
  endtask

  function automatic void note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch %0d: %s", mismatch_count, what);
  endfunction

  // Gap lengths: mostly the shortest, sometimes a handful, rarely a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t make_pixel(pixel_style_t style, int idx);
    in_item_t p;
    case (style)
      PIX_RAMP: begin
        p.red   = 8'(idx * 37);
        p.green = 8'(idx * 11 + 90);
        p.blue  = 8'(255 - idx * 23);
      end
      PIX_SATURATED: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      PIX_DIM: begin
        p.red   = 8'($urandom_range(0, 40));
        p.green = 8'($urandom_range(0, 40));
        p.blue  = 8'($urandom_range(0, 40));
      end
      default: begin
        p = 24'($urandom);
      end
    endcase
    return p;
  endfunction

  // Corner colors: every channel at 0 or 255, one bit of the index per channel.
  function automatic in_item_t corner_pixel(int i);
    return '{red:   (i & 1) ? 8'hFF : 8'h00,
             green: (i & 2) ? 8'hFF : 8'h00,
             blue:  (i & 4) ? 8'hFF : 8'h00};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port: setup phase, then access phase until pready.
  // ---------------------------------------------------------------------------
  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Mirror the register in the frame model once the write transaction lands.
    case (idx)
      REG_IMAGE_WIDTH:    cfg_width  = val[CFG_SIZE_W-1:0];
      REG_IMAGE_HEIGHT:   cfg_height = val[CFG_SIZE_W-1:0];
      REG_EDGE_THRESHOLD: cfg_thr    = val[CFG_THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_read_check(reg_index_t idx, logic [CFG_DATA_W-1:0] want);
    logic [CFG_DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      note_mismatch($sformatf("register %s read expected %0d got %0d", idx.name(), want, got));
    end
  endtask

  task automatic set_frame_config(int w_reg, int h_reg, int thr);
    cfg_write(REG_IMAGE_WIDTH, w_reg);
    cfg_write(REG_IMAGE_HEIGHT, h_reg);
    cfg_write(REG_EDGE_THRESHOLD, thr);
    cfg_read_check(REG_IMAGE_WIDTH, w_reg);
    cfg_read_check(REG_IMAGE_HEIGHT, h_reg);
    cfg_read_check(REG_EDGE_THRESHOLD, thr);
  endtask

  // Wait until every queued pixel went in and every expected result came out, then let
  // pixels that release nothing (such as row 0) clear the pipeline before touching registers.
  task automatic wait_until_quiet();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pix_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic stream_pixels(int count, pixel_style_t style);
    @(negedge clk);
    repeat (count) begin
      pixel_queue.push_back(make_pixel(style, ramp_index));
      ramp_index++;
    end
    pixels_pushed += count;
  endtask

  // Send one frame. With shrink set, stop partway, wait for silence, shrink the frame
  // and send only what the smaller geometry still needs to reach the frame end.
  task automatic run_frame(int w_reg, int h_reg, int thr, pixel_style_t style, bit shrink);
    int w;
    int h;
    int w2;
    int h2;
    int sent;
    int r;
    int c;
    set_frame_config(w_reg, h_reg, thr);
    w = clamp_size(w_reg, DEF_MAX_WIDTH);
    h = clamp_size(h_reg, DEF_MAX_HEIGHT);
    if (shrink && w >= 4 && h >= 4) begin
      sent = $urandom_range(w, w * (h - 1) - 1);
      stream_pixels(sent, style);
      wait_until_quiet();
      w2 = $urandom_range(MIN_SIZE, w - 1);
      h2 = $urandom_range(MIN_SIZE, h - 1);
      cfg_write(REG_IMAGE_WIDTH, w2);
      cfg_write(REG_IMAGE_HEIGHT, h2);
      r = (sent / w > h2 - 1) ? h2 - 1 : sent / w;
      c = (sent % w > w2 - 1) ? w2 - 1 : sent % w;
      stream_pixels((h2 - 1 - r) * w2 + (w2 - c), style);
    end else begin
      stream_pixels(w * h, style);
    end
    wait_until_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: predict on every accepted transaction, hold a stalled pixel,
  // insert random gaps after a pixel when the sender is idling.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) predict_pixel(pix);
      if (!(pix_valid && pix_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pix       <= pixel_queue.pop_front();
          pix_valid <= 1'b1;
          send_gap = (sender_idles && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: a requested long hold-off takes priority over random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_receiver
    if (rst) begin
      res_stall <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
      stall_left = idle_length() - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: sample on the falling edge, where the handshake that the next
  // rising edge will complete is already stable.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : result_checker
    out_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result row %0d col %0d edge %0b done %0b",
                                res.out_row, res.out_col, res.edge_res, res.frame_done));
      end else begin
        want = expected_results.pop_front();
        if (res.out_row !== want.out_row || res.out_col !== want.out_col ||
            res.edge_res !== want.edge_res || res.frame_done !== want.frame_done) begin
          note_mismatch($sformatf({"expected row %0d col %0d edge %0b done %0b, ",
                                   "got row %0d col %0d edge %0b done %0b"},
                                  want.out_row, want.out_col, want.edge_res, want.frame_done,
                                  res.out_row, res.out_col, res.edge_res, res.frame_done));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int           w;
    int           h;
    int           w_reg;
    int           h_reg;
    int           thr;
    int           random_start;
    bit           first_frame;
    bit           shrink;
    pixel_style_t style;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers must come out of reset at 640 x 480 with threshold 128.
    cfg_read_check(REG_IMAGE_WIDTH, RST_IMAGE_WIDTH);
    cfg_read_check(REG_IMAGE_HEIGHT, RST_IMAGE_HEIGHT);
    cfg_read_check(REG_EDGE_THRESHOLD, RST_EDGE_THRESHOLD);

    // Directed: undersized registers saturate to 3 x 3; threshold 0 marks any nonzero magnitude,
    // threshold 511 can never be exceeded. Corner colors drive every channel to both rails.
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    set_frame_config(1, 2, 0);
    @(negedge clk);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(corner_pixel(i));
    wait_until_quiet();
    set_frame_config(MIN_SIZE, MIN_SIZE, 511);
    @(negedge clk);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(corner_pixel(8 - i));
    wait_until_quiet();

    // Random frames of small size. The first one runs against a long receiver hold-off
    // with the sender never pausing, so the internal queue fills and the input stalls.
    first_frame  = 1'b1;
    random_start = pixels_pushed;
    while (pixels_pushed - random_start < RANDOM_ITEMS) begin
      w = $urandom_range(MIN_SIZE, 8);
      h = $urandom_range(MIN_SIZE, 6);
      w_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MIN_SIZE - 1) : w;
      h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MIN_SIZE - 1) : h;
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 511;
        default: thr = $urandom_range(1, 300);
      endcase
      style  = pixel_style_t'($urandom_range(0, 3));
      shrink = ($urandom_range(0, 3) == 0);
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if (first_frame) begin
        w_reg = 8;
        h_reg = 6;
        shrink = 1'b0;
        sender_idles = 1'b0;
        hold_requests++;
        first_frame = 1'b0;
      end
      run_frame(w_reg, h_reg, thr, style, shrink);
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
